FILE: rtl/reconnect_backoff_scheduler_defines.svh
// Assertion macros used by the scheduler's top-level RTL file.
`ifndef RECONNECT_BACKOFF_SCHEDULER_DEFINES_SVH
`define RECONNECT_BACKOFF_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbs: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbs: next-cycle check failed");

`endif

FILE: rtl/rbs_pkg.sv
package rbs_pkg;

  localparam int unsigned DELAY_W  = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned TIME_W   = 63;
  localparam int unsigned FACTOR_W = 16;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  // Shared unit: 64-bit add/subtract, 32 x 20 multiply.
  localparam int unsigned ALU_W    = 64;
  localparam int unsigned MUL_A_W  = 32;
  localparam int unsigned MUL_B_W  = 20;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;

  localparam logic [TIME_W-1:0]   TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [MUL_B_W-1:0]  NS_PER_MS = MUL_B_W'(1000000);
  localparam logic [FACTOR_W-1:0] ONE_Q8    = FACTOR_W'(256);
  localparam logic [ALU_W-1:0]    ROUND_ADD = ALU_W'(255);

  // Event codes.
  localparam logic [FUNC_W-1:0] FN_FAIL = 2'd0;
  localparam logic [FUNC_W-1:0] FN_OK   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_POLL = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_INIT     = 3'd1;
  localparam logic [2:0] REG_MAX      = 3'd2;
  localparam logic [2:0] REG_FACTOR   = 3'd3;
  localparam logic [2:0] REG_LIMIT_EN = 3'd4;
  localparam logic [2:0] REG_LIMIT    = 3'd5;
  localparam logic [2:0] REG_CLEAR    = 3'd6;

  typedef struct packed {
    logic                policy_enabled;
    logic [DELAY_W-1:0]  first_backoff_ms;
    logic [DELAY_W-1:0]  backoff_cap_ms;
    logic [FACTOR_W-1:0] growth_factor_q8;
    logic                limit_attempts;
    logic [COUNT_W-1:0]  attempt_limit;
    logic                clear_on_success;
  } cfg_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULF,
    ST_RND,
    ST_DLY,
    ST_MULN,
    ST_ADDT,
    ST_TIME,
    ST_CMP,
    ST_FIN
  } st_e;

endpackage

FILE: rtl/reconnect_backoff_scheduler.sv
// Channel   Direction  Handshake               Beat contents
// input     in         in_valid_i / in_stall_o func_i, now_ns_i
// output    out        out_valid_o / out_stall_i
//                                              scheduled .. pending_time_ns
// config    APB        psel, penable, pready   paddr, pwdata, prdata
//
// A failure that schedules steps through the factor multiply, rounding, delay
// clamp, nanosecond multiply, timestamp add, pending-time update, compare and
// final step, skipping the multiply and rounding when no delay is held yet;
// every other event goes straight to the compare and final step. All steps
// share the single registered add/subtract/multiply unit.
// Reset clears control state, loads register defaults; no clearing pass.
// A waiting result does not block the next accept; a stalled output only
// holds the sequencer in its final step.
`include "reconnect_backoff_scheduler_defines.svh"

module reconnect_backoff_scheduler import rbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [TIME_W-1:0]   now_ns_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                scheduled_o,
  output logic                can_attempt_o,
  output logic                should_reconnect_o,
  output logic [COUNT_W-1:0]  attempts_made_o,
  output logic [DELAY_W-1:0]  backoff_ms_o,
  output logic                is_exhausted_o,
  output logic                pending_valid_o,
  output logic [TIME_W-1:0]   pending_time_ns_o
);

  cfg_t             cfg;
  alu_req_t         alu_req;
  logic [ALU_W-1:0] alu_res;

  st_e                st_q, st_d;
  logic [DELAY_W-1:0] held_q, held_d;
  logic [COUNT_W-1:0] att_q, att_d, att_inc;
  logic               exh_q, exh_d;
  logic               pend_q, pend_d;
  logic [TIME_W-1:0]  pt_q, pt_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic               sched_q, sched_d;
  logic               init_q, init_d;
  logic               out_valid_q, out_valid_d;
  logic               load;

  logic                can_now, lim_hit;
  logic [FACTOR_W-1:0] factor;
  logic [DELAY_W-1:0]  scaled, src;

  logic                o_sched_q, o_can_q, o_recon_q, o_exh_q, o_pend_q;
  logic [COUNT_W-1:0]  o_att_q;
  logic [DELAY_W-1:0]  o_delay_q;
  logic [TIME_W-1:0]   o_time_q;

  rbs_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  rbs_alu u_alu (
    .clk_i(clk_i),
    .req_i(alu_req),
    .res_o(alu_res)
  );

  assign can_now = cfg.policy_enabled && !exh_q &&
                   (!cfg.limit_attempts || att_q < cfg.attempt_limit);
  assign lim_hit = cfg.limit_attempts && att_q >= cfg.attempt_limit;
  assign att_inc = (att_q == {COUNT_W{1'b1}}) ? att_q : att_q + COUNT_W'(1);
  assign factor  = (cfg.growth_factor_q8 < ONE_Q8) ? ONE_Q8 : cfg.growth_factor_q8;

  // The rounded product sits in alu_res; drop the eight fraction bits and
  // saturate to 32 bits.
  assign scaled = (|alu_res[ALU_W-1:DELAY_W+8]) ? {DELAY_W{1'b1}}
                                                 : alu_res[DELAY_W+7:8];
  assign src    = init_q ? cfg.first_backoff_ms : scaled;

  assign in_stall_o = (st_q != ST_IDLE);

  always_comb begin
    st_d    = st_q;
    held_d  = held_q;
    att_d   = att_q;
    exh_d   = exh_q;
    pend_d  = pend_q;
    pt_d    = pt_q;
    now_d   = now_q;
    sched_d = sched_q;
    init_d  = init_q;
    load    = 1'b0;
    alu_req = '{op: ALU_ADD, a: '0, b: '0};
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          now_d   = now_ns_i;
          sched_d = 1'b0;
          st_d    = ST_CMP;
          case (func_i)
            FN_FAIL: begin
              if (!cfg.policy_enabled) begin
                exh_d  = 1'b0;
                pend_d = 1'b0;
                pt_d   = '0;
              end else if (!can_now) begin
                exh_d  = lim_hit;
                pend_d = 1'b0;
                pt_d   = '0;
              end else begin
                sched_d = 1'b1;
                init_d  = (held_q == '0);
                st_d    = (held_q == '0) ? ST_DLY : ST_MULF;
              end
            end
            FN_OK: begin
              if (cfg.clear_on_success) begin
                held_d = '0;
                att_d  = '0;
              end
              exh_d  = 1'b0;
              pend_d = 1'b0;
              pt_d   = '0;
            end
            default: st_d = ST_CMP;
          endcase
        end
      end
      ST_MULF: begin
        alu_req = '{op: ALU_MUL, a: {{(ALU_W-DELAY_W){1'b0}}, held_q},
                    b: {{(ALU_W-FACTOR_W){1'b0}}, factor}};
        st_d = ST_RND;
      end
      ST_RND: begin
        alu_req = '{op: ALU_ADD, a: alu_res, b: ROUND_ADD};
        st_d = ST_DLY;
      end
      ST_DLY: begin
        held_d = (src > cfg.backoff_cap_ms) ? cfg.backoff_cap_ms : src;
        st_d   = ST_MULN;
      end
      ST_MULN: begin
        alu_req = '{op: ALU_MUL, a: {{(ALU_W-DELAY_W){1'b0}}, held_q},
                    b: {{(ALU_W-MUL_B_W){1'b0}}, NS_PER_MS}};
        st_d = ST_ADDT;
      end
      ST_ADDT: begin
        alu_req = '{op: ALU_ADD, a: {1'b0, now_q}, b: alu_res};
        st_d = ST_TIME;
      end
      ST_TIME: begin
        // The sum cannot wrap 64 bits, so reaching the top timestamp saturates.
        pt_d   = (alu_res >= {1'b0, TIME_MAX}) ? TIME_MAX : alu_res[TIME_W-1:0];
        pend_d = 1'b1;
        att_d  = att_inc;
        exh_d  = cfg.limit_attempts && (att_inc >= cfg.attempt_limit);
        st_d   = ST_CMP;
      end
      ST_CMP: begin
        alu_req = '{op: ALU_SUB, a: {1'b0, now_q}, b: {1'b0, pt_q}};
        st_d = ST_FIN;
      end
      ST_FIN: begin
        // Keep the compare running so the difference survives a stalled output.
        alu_req = '{op: ALU_SUB, a: {1'b0, now_q}, b: {1'b0, pt_q}};
        if (!out_valid_q || !out_stall_i) begin
          load = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      held_q      <= '0;
      att_q       <= '0;
      exh_q       <= 1'b0;
      pend_q      <= 1'b0;
      pt_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      held_q      <= held_d;
      att_q       <= att_d;
      exh_q       <= exh_d;
      pend_q      <= pend_d;
      pt_q        <= pt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    sched_q <= sched_d;
    init_q  <= init_d;
    if (load) begin
      o_sched_q <= sched_q;
      o_can_q   <= can_now;
      // A clear sign bit of the difference means now is at or past the time.
      o_recon_q <= cfg.policy_enabled && pend_q && !alu_res[ALU_W-1];
      o_att_q   <= att_q;
      o_delay_q <= held_q;
      o_exh_q   <= exh_q;
      o_pend_q  <= pend_q;
      o_time_q  <= pend_q ? pt_q : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign scheduled_o        = o_sched_q;
  assign can_attempt_o      = o_can_q;
  assign should_reconnect_o = o_recon_q;
  assign attempts_made_o    = o_att_q;
  assign backoff_ms_o       = o_delay_q;
  assign is_exhausted_o     = o_exh_q;
  assign pending_valid_o    = o_pend_q;
  assign pending_time_ns_o  = o_time_q;

  `RBS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `RBS_ASSERT_SAME(a_sched_pending, clk_i, rst_ni, out_valid_o && scheduled_o, pending_valid_o)
  `RBS_ASSERT_SAME(a_delay_clamped, clk_i, rst_ni, out_valid_o && scheduled_o, backoff_ms_o <= cfg.backoff_cap_ms)

endmodule

FILE: rtl/rbs_cfg.sv
module rbs_cfg import rbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_ENABLE:   cfg_d.policy_enabled   = pwdata[0];
        REG_INIT:     cfg_d.first_backoff_ms = pwdata;
        REG_MAX:      cfg_d.backoff_cap_ms   = pwdata;
        REG_FACTOR:   cfg_d.growth_factor_q8 = pwdata[FACTOR_W-1:0];
        REG_LIMIT_EN: cfg_d.limit_attempts   = pwdata[0];
        REG_LIMIT:    cfg_d.attempt_limit    = pwdata;
        REG_CLEAR:    cfg_d.clear_on_success = pwdata[0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE:   prdata = {{(DATA_W-1){1'b0}}, cfg_q.policy_enabled};
      REG_INIT:     prdata = cfg_q.first_backoff_ms;
      REG_MAX:      prdata = cfg_q.backoff_cap_ms;
      REG_FACTOR:   prdata = {{(DATA_W-FACTOR_W){1'b0}}, cfg_q.growth_factor_q8};
      REG_LIMIT_EN: prdata = {{(DATA_W-1){1'b0}}, cfg_q.limit_attempts};
      REG_LIMIT:    prdata = cfg_q.attempt_limit;
      REG_CLEAR:    prdata = {{(DATA_W-1){1'b0}}, cfg_q.clear_on_success};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.policy_enabled   <= 1'b1;
      cfg_q.first_backoff_ms <= DELAY_W'(1000);
      cfg_q.backoff_cap_ms   <= DELAY_W'(30000);
      cfg_q.growth_factor_q8 <= FACTOR_W'(512);
      cfg_q.limit_attempts   <= 1'b0;
      cfg_q.attempt_limit    <= '0;
      cfg_q.clear_on_success <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/rbs_alu.sv
module rbs_alu import rbs_pkg::*; (
  input  logic             clk_i,
  input  alu_req_t         req_i,
  output logic [ALU_W-1:0] res_o
);

  logic [MUL_P_W-1:0] prod;
  logic [ALU_W-1:0]   res_d, res_q;

  assign prod  = req_i.a[MUL_A_W-1:0] * req_i.b[MUL_B_W-1:0];
  assign res_o = res_q;

  always_comb begin
    case (req_i.op)
      ALU_ADD: res_d = req_i.a + req_i.b;
      ALU_SUB: res_d = req_i.a - req_i.b;
      ALU_MUL: res_d = {{(ALU_W-MUL_P_W){1'b0}}, prod};
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule
